@@ rtl/core/bbmm_pkg.sv @@
// Shared types, codes and note tables for the button box MIDI mapper.
// No dependencies; used by bbmm_note_unit and button_box_midi_mapper.
package bbmm_pkg;

	localparam int TREBLE_ROWS    = 3;
	localparam int TREBLE_COLUMNS = 11;
	localparam int BASS_COUNT     = 12;
	localparam int KEY_COUNT      = 5;

	// event opcodes
	localparam logic [2:0] OP_TREBLE_PRESS   = 3'd0;
	localparam logic [2:0] OP_TREBLE_RELEASE = 3'd1;
	localparam logic [2:0] OP_BASS_PRESS     = 3'd2;
	localparam logic [2:0] OP_BASS_RELEASE   = 3'd3;
	localparam logic [2:0] OP_BELLOWS_IN     = 3'd4;
	localparam logic [2:0] OP_BELLOWS_OUT    = 3'd5;
	localparam logic [2:0] OP_CLEAR          = 3'd6;

	// message kinds
	localparam logic [1:0] KIND_ON  = 2'd0;
	localparam logic [1:0] KIND_OFF = 2'd1;
	localparam logic [1:0] KIND_ALL = 2'd2;

	localparam logic [1:0] CH_BASS = 2'd3;

	// register indexes
	localparam logic [1:0] CFG_TUNING_KEY     = 2'd0;
	localparam logic [1:0] CFG_REVERSE_LAYOUT = 2'd1;
	localparam logic [1:0] CFG_NOTE_VELOCITY  = 2'd2;

	localparam logic [2:0] KEY_MAX = 3'd4;

	typedef struct packed {
		logic [2:0] opcode;
		logic [1:0] row;
		logic [3:0] column;
		logic [3:0] bass_button;
	} bbmm_evt_t;

	typedef struct packed {
		logic [1:0] msg_kind;
		logic [1:0] channel;
		logic [6:0] note;
		logic [6:0] velocity;
		logic       last;
	} bbmm_msg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TREBLE,
		ST_BASS,
		ST_FLUSH
	} bbmm_state_t;

	// one note lookup: a treble position or a bass chord tone
	typedef struct packed {
		logic       is_bass;
		logic [1:0] row;
		logic [3:0] column;
		logic [3:0] bass;
		logic       tone;
		logic       bellows;
		logic [2:0] key;
		logic       reverse;
	} bbmm_note_req_t;

	// [mapped column][bellows]
	localparam logic [6:0] BASE_NOTE [TREBLE_COLUMNS][2] = '{
		'{7'd52, 7'd57}, '{7'd55, 7'd59}, '{7'd60, 7'd62}, '{7'd64, 7'd65},
		'{7'd67, 7'd69}, '{7'd72, 7'd71}, '{7'd76, 7'd74}, '{7'd79, 7'd77},
		'{7'd84, 7'd81}, '{7'd88, 7'd83}, '{7'd91, 7'd86}
	};

	// [key][row]
	localparam logic signed [3:0] ROW_OFFSET [KEY_COUNT][TREBLE_ROWS] = '{
		'{ 4'sd3, -4'sd2, -4'sd7},
		'{ 4'sd5,  4'sd0, -4'sd5},
		'{ 4'sd7,  4'sd2, -4'sd3},
		'{ 4'sd7,  4'sd2,  4'sd1},
		'{ 4'sd1,  4'sd0, -4'sd1}
	};

	// [key][button][bellows][tone]
	localparam logic [6:0] CHORD [KEY_COUNT][BASS_COUNT][2][2] = '{
		'{
			'{'{7'd41, 7'd53}, '{7'd36, 7'd48}}, '{'{7'd65, 7'd60}, '{7'd60, 7'd67}},
			'{'{7'd38, 7'd50}, '{7'd43, 7'd55}}, '{'{7'd62, 7'd69}, '{7'd67, 7'd62}},
			'{'{7'd46, 7'd58}, '{7'd41, 7'd53}}, '{'{7'd70, 7'd65}, '{7'd65, 7'd60}},
			'{'{7'd43, 7'd55}, '{7'd36, 7'd48}}, '{'{7'd67, 7'd62}, '{7'd60, 7'd67}},
			'{'{7'd39, 7'd51}, '{7'd46, 7'd58}}, '{'{7'd63, 7'd70}, '{7'd70, 7'd65}},
			'{'{7'd44, 7'd56}, '{7'd44, 7'd56}}, '{'{7'd68, 7'd63}, '{7'd68, 7'd63}}
		},
		'{
			'{'{7'd43, 7'd55}, '{7'd38, 7'd50}}, '{'{7'd67, 7'd62}, '{7'd62, 7'd69}},
			'{'{7'd40, 7'd52}, '{7'd45, 7'd57}}, '{'{7'd64, 7'd71}, '{7'd69, 7'd64}},
			'{'{7'd36, 7'd48}, '{7'd43, 7'd55}}, '{'{7'd60, 7'd67}, '{7'd67, 7'd62}},
			'{'{7'd45, 7'd57}, '{7'd38, 7'd50}}, '{'{7'd69, 7'd64}, '{7'd62, 7'd69}},
			'{'{7'd41, 7'd53}, '{7'd36, 7'd48}}, '{'{7'd65, 7'd60}, '{7'd60, 7'd67}},
			'{'{7'd46, 7'd58}, '{7'd46, 7'd58}}, '{'{7'd70, 7'd65}, '{7'd70, 7'd65}}
		},
		'{
			'{'{7'd45, 7'd57}, '{7'd40, 7'd52}}, '{'{7'd69, 7'd64}, '{7'd64, 7'd71}},
			'{'{7'd42, 7'd54}, '{7'd47, 7'd59}}, '{'{7'd66, 7'd61}, '{7'd71, 7'd66}},
			'{'{7'd38, 7'd50}, '{7'd45, 7'd57}}, '{'{7'd62, 7'd69}, '{7'd69, 7'd64}},
			'{'{7'd47, 7'd59}, '{7'd40, 7'd52}}, '{'{7'd71, 7'd66}, '{7'd64, 7'd71}},
			'{'{7'd43, 7'd55}, '{7'd38, 7'd50}}, '{'{7'd67, 7'd62}, '{7'd62, 7'd69}},
			'{'{7'd36, 7'd48}, '{7'd36, 7'd48}}, '{'{7'd60, 7'd67}, '{7'd60, 7'd67}}
		},
		'{
			'{'{7'd45, 7'd57}, '{7'd40, 7'd52}}, '{'{7'd69, 7'd64}, '{7'd64, 7'd71}},
			'{'{7'd42, 7'd54}, '{7'd47, 7'd59}}, '{'{7'd66, 7'd61}, '{7'd71, 7'd66}},
			'{'{7'd38, 7'd50}, '{7'd45, 7'd57}}, '{'{7'd62, 7'd69}, '{7'd69, 7'd64}},
			'{'{7'd47, 7'd59}, '{7'd40, 7'd52}}, '{'{7'd71, 7'd66}, '{7'd64, 7'd71}},
			'{'{7'd43, 7'd55}, '{7'd38, 7'd50}}, '{'{7'd67, 7'd62}, '{7'd62, 7'd69}},
			'{'{7'd36, 7'd48}, '{7'd36, 7'd48}}, '{'{7'd60, 7'd67}, '{7'd60, 7'd67}}
		},
		'{
			'{'{7'd42, 7'd54}, '{7'd42, 7'd54}}, '{'{7'd47, 7'd59}, '{7'd47, 7'd59}},
			'{'{7'd40, 7'd52}, '{7'd40, 7'd52}}, '{'{7'd45, 7'd57}, '{7'd45, 7'd57}},
			'{'{7'd38, 7'd50}, '{7'd38, 7'd50}}, '{'{7'd43, 7'd55}, '{7'd43, 7'd55}},
			'{'{7'd36, 7'd48}, '{7'd36, 7'd48}}, '{'{7'd41, 7'd53}, '{7'd41, 7'd53}},
			'{'{7'd46, 7'd58}, '{7'd46, 7'd58}}, '{'{7'd39, 7'd51}, '{7'd39, 7'd51}},
			'{'{7'd44, 7'd56}, '{7'd44, 7'd56}}, '{'{7'd37, 7'd49}, '{7'd37, 7'd49}}
		}
	};

endpackage

@@ rtl/core/bbmm_note_unit.sv @@
// Shared note lookup: treble base note plus row offset, or a bass chord tone.
// Depends on bbmm_pkg for the tables and the request struct.
module bbmm_note_unit
	import bbmm_pkg::*;
(
	input  bbmm_note_req_t req,
	output logic [6:0]     note
);

	logic [2:0] key_c;
	logic [3:0] tk;
	logic [3:0] tk_m;
	logic [1:0] row_i;
	logic [3:0] bk;
	logic [7:0] sum;
	logic signed [3:0] offs;

	always_comb begin
		key_c = (req.key > KEY_MAX) ? KEY_MAX : req.key;
		row_i = (req.row == 2'd3) ? 2'd0 : req.row;

		// column mapping per row; rows 0 and 2 are one column short
		case (req.row)
			2'd0:    tk = req.reverse ? 4'd9 - req.column : req.column;
			2'd1:    tk = req.reverse ? 4'd10 - req.column : req.column;
			default: tk = req.reverse ? 4'd10 - req.column : req.column + 4'd1;
		endcase
		tk_m = (tk > 4'd10) ? tk - 4'd11 : tk;

		offs = ROW_OFFSET[key_c][row_i];
		sum  = {1'b0, BASE_NOTE[tk_m][req.bellows]} + {{4{offs[3]}}, offs};

		bk = req.reverse ? 4'd11 - req.bass : req.bass;
		if (bk > 4'd11)
			bk = bk - 4'd12;

		note = req.is_bass ? CHORD[key_c][bk][req.bellows][req.tone] : sum[6:0];
	end

endmodule

@@ rtl/core/button_box_midi_mapper.sv @@
// Top level of the button box MIDI mapper: event decode, held-button state,
// scan sequencer and output register. Depends on bbmm_pkg and bbmm_note_unit.
//
//   channel  signals                      direction  carries
//   evt      evt_valid/evt_ready/evt      in         one button or bellows request
//   msg      msg_valid/msg_ready/msg      out        one MIDI note message
//   cfg      cfg_we/cfg_index/cfg_data    in         register write, no wait
//
// A treble event is accepted, looked up and flushed; a bass event looks up both
//   chord tones first; a bellows change walks all 33 treble slots and 24 bass
//   chord tones through the one note unit, one slot per cycle unless stalled.
// A one-deep pending register holds the newest message so that the final one
//   can be marked last; the output register frees the scan from the consumer.
// Stalls: the scan waits on a held slot only when both pending and output are full.
// Reset clears held flags, bellows, config to defaults and all valid flags.
module button_box_midi_mapper
	import bbmm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       evt_valid,
	output logic       evt_ready,
	input  bbmm_evt_t  evt,
	output logic       msg_valid,
	input  logic       msg_ready,
	output bbmm_msg_t  msg,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [6:0] cfg_data
);

	bbmm_state_t state_q, state_d;

	// configuration
	logic [2:0] key_q;
	logic       reverse_q;
	logic [6:0] velocity_q;

	// held state
	logic [TREBLE_COLUMNS-1:0] treble_held_q [TREBLE_ROWS];
	logic [BASS_COUNT-1:0]     bass_held_q;
	logic                      bellows_q;

	// sequencer cursor
	logic       single_q;   // one event's own notes, not a bellows rescan
	logic [1:0] kind_q;
	logic [1:0] row_q;
	logic [3:0] col_q;
	logic [3:0] bass_q;
	logic       tone_q;

	// pending and output messages
	logic      pend_valid_q;
	bbmm_msg_t pend_q;
	logic      msg_valid_q;
	bbmm_msg_t msg_q;

	// decode of the incoming request
	logic       evt_fire;
	logic       press;
	logic       tre_present;
	logic       tre_cur;
	logic       tre_change;
	logic       bass_change;
	logic       bellows_want;
	logic       bellows_change;
	logic       is_clear;
	bbmm_state_t evt_next;

	// scan step
	logic           out_free;
	logic           step_ok;
	logic           hit;
	logic           advance;
	logic           take_cand;
	logic           flush;
	bbmm_note_req_t nreq;
	logic [6:0]     cand_note;
	bbmm_msg_t      cand;
	bbmm_msg_t      all_msg;
	bbmm_msg_t      out_next;

	assign evt_ready = (state_q == ST_IDLE);
	assign evt_fire  = evt_valid && evt_ready;
	assign msg_valid = msg_valid_q;
	assign msg       = msg_q;

	always_comb begin
		press        = (evt.opcode == OP_TREBLE_PRESS) || (evt.opcode == OP_BASS_PRESS);
		tre_present  = (evt.row < 2'd3) && (evt.column < 4'd11) &&
		               ((evt.row == 2'd1) || (evt.column < 4'd10));
		tre_cur      = tre_present ? treble_held_q[evt.row][evt.column] : 1'b0;
		bellows_want = (evt.opcode == OP_BELLOWS_IN);
		tre_change   = 1'b0;
		bass_change  = 1'b0;
		bellows_change = 1'b0;
		is_clear     = 1'b0;
		evt_next     = ST_IDLE;
		unique case (evt.opcode)
			OP_TREBLE_PRESS, OP_TREBLE_RELEASE: begin
				tre_change = tre_present && (tre_cur != press);
				if (tre_change)
					evt_next = ST_TREBLE;
			end
			OP_BASS_PRESS, OP_BASS_RELEASE: begin
				bass_change = (evt.bass_button < 4'd12) &&
				              (bass_held_q[evt.bass_button] != press);
				if (bass_change)
					evt_next = ST_BASS;
			end
			OP_BELLOWS_IN, OP_BELLOWS_OUT: begin
				bellows_change = (bellows_q != bellows_want);
				if (bellows_change)
					evt_next = ST_TREBLE;
			end
			OP_CLEAR: begin
				is_clear = 1'b1;
				evt_next = ST_FLUSH;
			end
			default: evt_next = ST_IDLE;
		endcase
	end

	// note unit request always comes from the cursor
	always_comb begin
		nreq.is_bass = (state_q == ST_BASS);
		nreq.row     = row_q;
		nreq.column  = col_q;
		nreq.bass    = bass_q;
		nreq.tone    = tone_q;
		nreq.bellows = bellows_q;
		nreq.key     = key_q;
		nreq.reverse = reverse_q;
	end

	bbmm_note_unit u_note (
		.req  (nreq),
		.note (cand_note)
	);

	always_comb begin
		cand.msg_kind = single_q ? kind_q : KIND_ON;
		cand.channel  = (state_q == ST_BASS) ? CH_BASS : row_q;
		cand.note     = cand_note;
		cand.velocity = velocity_q;
		cand.last     = 1'b0;

		all_msg.msg_kind = KIND_ALL;
		all_msg.channel  = 2'd0;
		all_msg.note     = 7'd0;
		all_msg.velocity = 7'd0;
		all_msg.last     = 1'b0;
	end

	// sequencer
	always_comb begin
		out_free  = !msg_valid_q || msg_ready;
		step_ok   = !pend_valid_q || out_free;
		state_d   = state_q;
		advance   = 1'b0;
		take_cand = 1'b0;
		flush     = 1'b0;
		hit       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (evt_fire)
					state_d = evt_next;
			end
			ST_TREBLE: begin
				hit = single_q ||
				      (((row_q == 2'd1) || (col_q != 4'd10)) && treble_held_q[row_q][col_q]);
				if (!hit || step_ok) begin
					advance   = 1'b1;
					take_cand = hit;
					if (single_q)
						state_d = ST_FLUSH;
					else if ((row_q == 2'd2) && (col_q == 4'd10))
						state_d = ST_BASS;
				end
			end
			ST_BASS: begin
				hit = single_q || bass_held_q[bass_q];
				if (!hit || step_ok) begin
					advance   = 1'b1;
					take_cand = hit;
					if (tone_q && (single_q || (bass_q == 4'd11)))
						state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					flush   = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// pending message moves out; only the flush marks it last
	always_comb begin
		out_next      = pend_q;
		out_next.last = flush;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// config and held state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q       <= 3'd2;
			reverse_q   <= 1'b0;
			velocity_q  <= 7'd127;
			for (int i = 0; i < TREBLE_ROWS; i++)
				treble_held_q[i] <= '0;
			bass_held_q <= '0;
			bellows_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_TUNING_KEY:     key_q      <= cfg_data[2:0];
					CFG_REVERSE_LAYOUT: reverse_q  <= cfg_data[0];
					CFG_NOTE_VELOCITY:  velocity_q <= cfg_data;
					default: ;
				endcase
			end
			if (evt_fire) begin
				if (tre_change)
					treble_held_q[evt.row][evt.column] <= press;
				if (bass_change)
					bass_held_q[evt.bass_button] <= press;
				if (bellows_change)
					bellows_q <= bellows_want;
				if (is_clear)
					for (int i = 0; i < TREBLE_ROWS; i++)
						treble_held_q[i] <= '0;
			end
		end
	end

	// cursor and valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			single_q     <= 1'b0;
			kind_q       <= KIND_ON;
			row_q        <= '0;
			col_q        <= '0;
			bass_q       <= '0;
			tone_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			msg_valid_q  <= 1'b0;
		end else begin
			if (evt_fire) begin
				single_q <= !bellows_change;
				kind_q   <= press ? KIND_ON : KIND_OFF;
				row_q    <= bellows_change ? 2'd0 : evt.row;
				col_q    <= bellows_change ? 4'd0 : evt.column;
				bass_q   <= evt.bass_button;
				tone_q   <= 1'b0;
				if (bellows_change || is_clear)
					pend_valid_q <= 1'b1;
			end else if (advance) begin
				if (state_q == ST_TREBLE) begin
					if (col_q == 4'd10) begin
						col_q <= 4'd0;
						row_q <= row_q + 2'd1;
					end else begin
						col_q <= col_q + 4'd1;
					end
					if (!single_q) begin
						bass_q <= 4'd0;
						tone_q <= 1'b0;
					end
				end else begin
					tone_q <= !tone_q;
					if (tone_q)
						bass_q <= bass_q + 4'd1;
				end
			end

			if (take_cand)
				pend_valid_q <= 1'b1;
			else if (flush)
				pend_valid_q <= 1'b0;

			if (flush || (take_cand && pend_valid_q))
				msg_valid_q <= 1'b1;
			else if (msg_ready)
				msg_valid_q <= 1'b0;
		end
	end

	// message payload
	always_ff @(posedge clk) begin
		if (evt_fire && (bellows_change || is_clear))
			pend_q <= all_msg;
		else if (take_cand)
			pend_q <= cand;

		if (flush || (take_cand && pend_valid_q))
			msg_q <= out_next;
	end

`ifndef SYNTH
	a_flush_has_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> pend_valid_q)
		else $error("flush state without a pending message");

	a_bellows_all_off: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_fire && bellows_change) |=> (pend_valid_q && (pend_q.msg_kind == KIND_ALL)))
		else $error("bellows change did not queue all-notes-off");

	a_clear_releases: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_fire && (evt.opcode == OP_CLEAR)) |=>
		((treble_held_q[0] == '0) && (treble_held_q[1] == '0) && (treble_held_q[2] == '0)))
		else $error("clear left treble buttons held");

	a_all_off_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(msg_valid && (msg.msg_kind == KIND_ALL)) |->
		((msg.note == 7'd0) && (msg.velocity == 7'd0) && (msg.channel == 2'd0)))
		else $error("all-notes-off with nonzero fields");
`endif

endmodule
